FILE: sv/ufd_pkg.sv
// Shared types, constants and the CRC byte update for the UART frame deframer.
`timescale 1ns / 1ps
`default_nettype none

package ufd_pkg;

  localparam int MAX_FRAME_DEF  = 64;
  localparam int FRAME_OVERHEAD = 7;
  localparam int PAYLOAD_START  = 4;
  localparam int STORE_DEPTH    = 64;
  localparam int STORE_AW       = $clog2(STORE_DEPTH);
  localparam int ITEM_MAX       = 57;
  // wide enough for a frame position or total up to 7 + 255
  localparam int POS_W          = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_TAIL_VALUE    = 3'd2,
    REG_COMMAND_CODE  = 3'd3,
    REG_ITEM_LENGTH   = 3'd4,
    REG_CRC_INIT      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  tail_value;
    logic [7:0]  command_code;
    logic [5:0]  item_length;
    logic [15:0] crc_init;
  } cfg_t;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0]  TAIL_VALUE_RST    = 8'h55;
  localparam logic [7:0]  COMMAND_CODE_RST  = 8'h01;
  localparam logic [5:0]  ITEM_LENGTH_RST   = 6'd8;
  localparam logic [15:0] CRC_INIT_RST      = 16'hFFFF;

  // CRC-16/CCITT, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ufd_cfg_regs.sv
// Configuration register bank of the UART frame deframer.
`timescale 1ns / 1ps
`default_nettype none

module ufd_cfg_regs
  import ufd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_wdata[7:0];
        REG_HEADER_SECOND: cfg_nxt.header_second = cfg_wdata[7:0];
        REG_TAIL_VALUE:    cfg_nxt.tail_value    = cfg_wdata[7:0];
        REG_COMMAND_CODE:  cfg_nxt.command_code  = cfg_wdata[7:0];
        REG_ITEM_LENGTH:   cfg_nxt.item_length   = cfg_wdata[5:0];
        REG_CRC_INIT:      cfg_nxt.crc_init      = cfg_wdata[15:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= HEADER_FIRST_RST;
      cfg_r.header_second <= HEADER_SECOND_RST;
      cfg_r.tail_value    <= TAIL_VALUE_RST;
      cfg_r.command_code  <= COMMAND_CODE_RST;
      cfg_r.item_length   <= ITEM_LENGTH_RST;
      cfg_r.crc_init      <= CRC_INIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/uart_frame_deframer_crc16.sv
// Top level of the UART frame deframer with CRC-16/CCITT check.
//
// Received bytes are taken one word per cycle while the block hunts for a frame
// (header, header, command, length, payload, CRC low, CRC high, tail). Payload
// bytes go into a 64-entry RAM as they arrive and the CRC is updated in the same
// cycle. When the tail of a good frame with the wanted command lands, input stalls
// and the first min(item_length, 57) payload bytes are read back from the RAM's
// single read port, one result per cycle while out_ready is high; a CRC error
// report is a single result that also stalls input. The RAM needs no clearing
// after reset: every entry read has been written earlier in the same frame.
`timescale 1ns / 1ps
`default_nettype none

module uart_frame_deframer_crc16
  import ufd_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // received bytes
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_rx_byte,
  // results
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_result_kind,
  output logic [7:0]                 out_data_byte,
  output logic [5:0]                 out_byte_index,
  output logic                       out_last_byte,
  output logic [31:0]                out_crc_error_total,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_FRAME + 1);

  typedef enum logic [1:0] {
    ST_HUNT = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  cfg_t cfg;

  ufd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t      state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcv_r, rcv_nxt;
  logic [31:0] err_cnt_r, err_cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  rd_data_r;

  logic [7:0]  payload_mem [STORE_DEPTH];

  logic                wr_en;
  logic [STORE_AW-1:0] wr_addr;
  logic                rd_en;
  logic [STORE_AW-1:0] rd_addr;

  logic             in_acc;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_w;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] pay_end;
  logic [POS_W-1:0] k_w;
  logic [POS_W-1:0] total_w;
  logic [7:0]       len_sel;
  logic [5:0]       need;
  logic [5:0]       idx_inc;

  assign in_ready = (state_r == ST_HUNT);
  assign in_acc   = in_valid && in_ready;
  assign b        = in_rx_byte;

  assign need    = (cfg.item_length > 6'(ITEM_MAX)) ? 6'(ITEM_MAX) : cfg.item_length;
  assign pos_w   = POS_W'(cnt_r);
  assign pos_inc = pos_w + POS_W'(1);
  assign pay_end = POS_W'(PAYLOAD_START) + POS_W'(len_r);
  assign k_w     = pos_w - POS_W'(PAYLOAD_START);
  // the length byte counts towards the total in the very word that carries it
  assign len_sel = (pos_w == POS_W'(3)) ? b : len_r;
  assign total_w = POS_W'(len_sel) + POS_W'(FRAME_OVERHEAD);
  assign idx_inc = idx_r + 6'd1;
  assign wr_addr = k_w[STORE_AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    crc_nxt       = crc_r;
    rcv_nxt       = rcv_r;
    err_cnt_nxt   = err_cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    last_nxt      = last_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;

    case (state_r)
      ST_HUNT: begin
        if (in_acc) begin
          if (cnt_r == CW'(0)) begin
            if (b == cfg.header_first) cnt_nxt = CW'(1);
          end else if (cnt_r == CW'(1)) begin
            if (b == cfg.header_second) begin
              cnt_nxt = CW'(2);
            end else if (b != cfg.header_first) begin
              cnt_nxt = CW'(0);
            end
          end else if (pos_w >= POS_W'(MAX_FRAME)) begin
            cnt_nxt = CW'(0);
          end else begin
            cnt_nxt = CW'(pos_inc);
            if (pos_w == POS_W'(2)) begin
              // command word: CRC restarts from the configured seed
              cmd_nxt = b;
              crc_nxt = crc_feed(cfg.crc_init, b);
            end else begin
              if (pos_w == POS_W'(3)) begin
                len_nxt = b;
                crc_nxt = crc_feed(crc_r, b);
              end else if (pos_w < pay_end) begin
                wr_en   = (k_w < POS_W'(STORE_DEPTH));
                crc_nxt = crc_feed(crc_r, b);
              end else if (pos_w == pay_end) begin
                rcv_nxt = {8'h00, b};
              end else if (pos_w == pay_end + POS_W'(1)) begin
                rcv_nxt = {b, rcv_r[7:0]};
              end

              if (total_w > POS_W'(MAX_FRAME)) begin
                cnt_nxt = CW'(0);
              end else if (pos_inc == total_w) begin
                cnt_nxt = CW'(0);
                if (b == cfg.tail_value) begin
                  if (crc_r != rcv_r) begin
                    err_cnt_nxt   = err_cnt_r + 32'd1;
                    out_valid_nxt = 1'b1;
                    kind_nxt      = 1'b1;
                    idx_nxt       = 6'd0;
                    last_nxt      = 1'b1;
                    state_nxt     = ST_EMIT;
                  end else if (cmd_r == cfg.command_code && len_r >= {2'b00, need} &&
                               need != 6'd0) begin
                    rd_en         = 1'b1;
                    rd_addr       = '0;
                    out_valid_nxt = 1'b1;
                    kind_nxt      = 1'b0;
                    idx_nxt       = 6'd0;
                    last_nxt      = (need == 6'd1);
                    state_nxt     = ST_EMIT;
                  end
                end
              end
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (last_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_HUNT;
          end else begin
            // fetch the next byte as this one leaves
            rd_en    = 1'b1;
            rd_addr  = STORE_AW'(idx_inc);
            idx_nxt  = idx_inc;
            last_nxt = (idx_inc == need - 6'd1);
          end
        end
      end
      default: begin
        state_nxt     = ST_HUNT;
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      cnt_r       <= '0;
      len_r       <= '0;
      cmd_r       <= '0;
      crc_r       <= CRC_INIT_RST;
      rcv_r       <= '0;
      err_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      cmd_r       <= cmd_nxt;
      crc_r       <= crc_nxt;
      rcv_r       <= rcv_nxt;
      err_cnt_r   <= err_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    last_r <= last_nxt;
  end

  // payload RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) payload_mem[wr_addr] <= b;
    if (rd_en) rd_data_r <= payload_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_data_byte       = kind_r ? 8'h00 : rd_data_r;
  assign out_byte_index      = idx_r;
  assign out_last_byte       = last_r;
  assign out_crc_error_total = err_cnt_r;

endmodule

`default_nettype wire

FILE: sv/ufd_checker.sv
// Port-level checker for the UART frame deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ufd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_result_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic [5:0]  out_byte_index,
  input wire logic        out_last_byte
);

  // no word is taken while results are pending
  a_stall_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input accepted while a result is pending");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind) |->
      (out_data_byte == 8'h00 && out_byte_index == 6'd0 && out_last_byte))
    else $error("malformed CRC error report");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_byte) |=>
      (out_valid && !out_result_kind &&
       out_byte_index == 6'($past(out_byte_index) + 6'd1)))
    else $error("item byte index did not advance by one");

  // a new run needs at least one more frame tail
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_byte) |=> !out_valid)
    else $error("result follows the last word of a run at once");

endmodule

bind uart_frame_deframer_crc16 ufd_checker u_ufd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_kind (out_result_kind),
  .out_data_byte   (out_data_byte),
  .out_byte_index  (out_byte_index),
  .out_last_byte   (out_last_byte)
);

`default_nettype wire
